/* hw/rtl/sab_pkg.sv */
package sab_pkg;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned RANK_W = 10;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SYM_W-1:0]  symbol;
    logic              last_symbol;
    logic [RANK_W-1:0] rank;
  } sab_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] suffix_start;
    logic [RANK_W-1:0] rank_echo;
    logic              out_of_range;
  } sab_res_t;

endpackage

/* hw/rtl/sab_ram.sv */
module sab_ram #(
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/suffix_array_builder.sv */
// A read request gives its result in the cycle after acceptance; appends give none.
// Throughput: one append or read request per cycle while idle. After the last symbol busy
// holds for the sentinel append, then per round: clear, count, prefix sum, place, renumber,
// copy; clear and prefix sum span classes 0..h, h the highest class (2^SYMBOL_BITS in the
// first round); 1 + ceil(log2 n) rounds, n = length+1 (one read and one write port per RAM).
// Reset: asynchronous, active low; clears length, build flag and sequencer, not the RAMs.
module suffix_array_builder
  import sab_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sab_req_t req_i,
  output logic     res_valid_o,
  output sab_res_t res_o
);

  // Index width covers positions 0..MAX_LEN (sentinel included).
  localparam int unsigned DEPTH   = MAX_LEN + 1;
  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned SYM_BKT = (1 << SYMBOL_BITS) + 1;
  localparam int unsigned BUCKETS = (DEPTH > SYM_BKT) ? DEPTH : SYM_BKT;
  localparam int unsigned BW      = $clog2(BUCKETS);
  localparam int unsigned CMP_W   = (IW > RANK_W) ? IW + 1 : RANK_W + 1;

  localparam logic [BW-1:0] SYM_MASK = BW'((1 << SYMBOL_BITS) - 1);
  localparam logic [BW-1:0] SYM_TOP  = BW'(1 << SYMBOL_BITS);
  localparam logic [IW:0]   LEN_MAX  = (IW + 1)'(MAX_LEN);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SENT  = 3'd1;  // append sentinel
  localparam logic [2:0] S_CLR   = 3'd2;  // clear buckets
  localparam logic [2:0] S_CNT   = 3'd3;  // histogram of classes
  localparam logic [2:0] S_PFX   = 3'd4;  // running sum
  localparam logic [2:0] S_PLACE = 3'd5;  // counting sort placement
  localparam logic [2:0] S_RENUM = 3'd6;  // renumber classes
  localparam logic [2:0] S_CPY   = 3'd7;  // new classes back to class store

  logic [2:0]    state_q, state_d;
  logic [1:0]    ph_q, ph_d;
  logic [IW:0]   len_q, len_d;
  logic [IW:0]   n_q, n_d;
  logic [IW:0]   k_q, k_d;
  logic          built_q, built_d;
  logic [IW-1:0] i_q, i_d;
  logic [BW-1:0] j_q, j_d;
  logic [IW-1:0] acc_q, acc_d;
  logic [BW-1:0] h_q, h_d;
  logic [BW-1:0] c_q, c_d;
  logic [IW-1:0] p_q, p_d;
  logic [IW-1:0] b_q, b_d;
  logic [BW-1:0] c1_q, c1_d;
  logic [BW-1:0] pc1_q, pc1_d;
  logic [BW-1:0] pc2_q, pc2_d;
  logic          rv_q, rv_d;
  logic          inr_q, inr_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  // RAM ports
  logic          cls_we, ord_we, osc_we, csc_we, bkt_we;
  logic [IW-1:0] cls_wa, cls_ra, ord_wa, ord_ra, osc_wa, osc_ra, csc_wa, csc_ra;
  logic [BW-1:0] bkt_wa, bkt_ra;
  logic [BW-1:0] cls_wd, cls_rd, csc_wd, csc_rd;
  logic [IW-1:0] ord_wd, ord_rd, osc_wd, osc_rd, bkt_wd, bkt_rd;

  sab_ram #(.DEPTH(DEPTH), .WIDTH(BW)) u_class (
    .clk_i, .we_i(cls_we), .waddr_i(cls_wa), .wdata_i(cls_wd), .raddr_i(cls_ra),
    .rdata_o(cls_rd));
  sab_ram #(.DEPTH(DEPTH), .WIDTH(BW)) u_class_scr (
    .clk_i, .we_i(csc_we), .waddr_i(csc_wa), .wdata_i(csc_wd), .raddr_i(csc_ra),
    .rdata_o(csc_rd));
  sab_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd), .raddr_i(ord_ra),
    .rdata_o(ord_rd));
  sab_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_order_scr (
    .clk_i, .we_i(osc_we), .waddr_i(osc_wa), .wdata_i(osc_wd), .raddr_i(osc_ra),
    .rdata_o(osc_rd));
  sab_ram #(.DEPTH(BUCKETS), .WIDTH(IW)) u_bucket (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_wa), .wdata_i(bkt_wd), .raddr_i(bkt_ra),
    .rdata_o(bkt_rd));

  logic          accept;
  logic [IW:0]   base;
  logic [IW:0]   p_sum, p_wrap;
  logic [IW:0]   q_sum, q_wrap;
  logic [IW-1:0] last_i;
  logic [BW-1:0] h_new;
  logic [IW:0]   k_next;
  logic          differs;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign last_i = IW'(n_q - (IW + 1)'(1));

  // Shift back by k (placement) and forward by k (renumbering), cyclic over n.
  assign p_sum  = {1'b0, ord_rd} + n_q - k_q;
  assign p_wrap = (p_sum >= n_q) ? p_sum - n_q : p_sum;
  assign q_sum  = {1'b0, b_q} + k_q;
  assign q_wrap = (q_sum >= n_q) ? q_sum - n_q : q_sum;
  assign k_next = (k_q == '0) ? (IW + 1)'(1) : {k_q[IW-1:0], 1'b0};
  assign differs = (c1_q != pc1_q) || (cls_rd != pc2_q);
  assign h_new  = (i_q == '0) ? '0 : h_q + BW'(differs);

  always_comb begin
    state_d = state_q;  ph_d   = ph_q;   len_d = len_q;  n_d   = n_q;
    k_d     = k_q;      built_d = built_q; i_d  = i_q;   j_d   = j_q;
    acc_d   = acc_q;    h_d    = h_q;    c_d   = c_q;    p_d   = p_q;
    b_d     = b_q;      c1_d   = c1_q;   pc1_d = pc1_q;  pc2_d = pc2_q;
    rv_d    = 1'b0;     inr_d  = inr_q;  rank_d = rank_q;
    base    = built_q ? '0 : len_q;
    cls_we = 1'b0; cls_wa = '0; cls_wd = '0; cls_ra = '0;
    csc_we = 1'b0; csc_wa = '0; csc_wd = '0; csc_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    ord_ra = IW'(CMP_W'(req_i.rank) + CMP_W'(1));
    osc_we = 1'b0; osc_wa = '0; osc_wd = '0; osc_ra = '0;
    bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0; bkt_ra = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_APPEND) begin
            built_d = 1'b0;
            len_d   = base;
            // symbol+1 is its first class; the sentinel later takes class 0
            if (base < LEN_MAX) begin
              cls_we = 1'b1;
              cls_wa = IW'(base);
              cls_wd = (BW'(req_i.symbol) & SYM_MASK) + BW'(1);
              ord_we = 1'b1;
              ord_wa = IW'(base);
              ord_wd = IW'(base);
              len_d  = base + (IW + 1)'(1);
            end
            if (req_i.last_symbol) begin
              state_d = S_SENT;
            end
          end else begin
            rv_d   = 1'b1;
            rank_d = req_i.rank;
            inr_d  = built_q && (CMP_W'(req_i.rank) < CMP_W'(len_q));
          end
        end
      end
      S_SENT: begin
        cls_we  = 1'b1;
        cls_wa  = IW'(len_q);
        cls_wd  = '0;
        ord_we  = 1'b1;
        ord_wa  = IW'(len_q);
        ord_wd  = IW'(len_q);
        n_d     = len_q + (IW + 1)'(1);
        h_d     = SYM_TOP;
        k_d     = '0;
        j_d     = '0;
        state_d = S_CLR;
      end
      S_CLR: begin
        bkt_we = 1'b1;
        bkt_wa = j_q;
        bkt_wd = '0;
        if (j_q == h_q) begin
          state_d = S_CNT;
          i_d     = '0;
          ph_d    = '0;
        end else begin
          j_d = j_q + BW'(1);
        end
      end
      S_CNT: begin
        cls_ra = i_q;
        bkt_ra = cls_rd;
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            c_d  = cls_rd;
            ph_d = 2'd2;
          end
          default: begin
            bkt_we = 1'b1;
            bkt_wa = c_q;
            bkt_wd = bkt_rd + IW'(1);
            ph_d   = 2'd0;
            if (i_q == last_i) begin
              state_d = S_PFX;
              j_d     = '0;
              acc_d   = '0;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
        endcase
      end
      S_PFX: begin
        bkt_ra = j_q;
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          bkt_we = 1'b1;
          bkt_wa = j_q;
          bkt_wd = acc_q + bkt_rd;
          acc_d  = acc_q + bkt_rd;
          ph_d   = 2'd0;
          if (j_q == h_q) begin
            state_d = S_PLACE;
            i_d     = last_i;
          end else begin
            j_d = j_q + BW'(1);
          end
        end
      end
      S_PLACE: begin
        ord_ra = i_q;
        cls_ra = IW'(p_wrap);
        bkt_ra = cls_rd;
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            p_d  = IW'(p_wrap);
            cls_ra = IW'(p_wrap);
            ph_d = 2'd2;
          end
          2'd2: begin
            c_d  = cls_rd;
            ph_d = 2'd3;
          end
          default: begin
            bkt_we = 1'b1;
            bkt_wa = c_q;
            bkt_wd = bkt_rd - IW'(1);
            osc_we = 1'b1;
            osc_wa = bkt_rd - IW'(1);
            osc_wd = p_q;
            ph_d   = 2'd0;
            if (i_q == '0) begin
              state_d = S_RENUM;
            end else begin
              i_d = i_q - IW'(1);
            end
          end
        endcase
      end
      S_RENUM: begin
        osc_ra = i_q;
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            b_d    = osc_rd;
            cls_ra = osc_rd;
            ph_d   = 2'd2;
          end
          2'd2: begin
            c1_d   = cls_rd;
            cls_ra = IW'(q_wrap);
            ph_d   = 2'd3;
          end
          default: begin
            csc_we = 1'b1;
            csc_wa = b_q;
            csc_wd = h_new;
            ord_we = 1'b1;
            ord_wa = i_q;
            ord_wd = b_q;
            h_d    = h_new;
            pc1_d  = c1_q;
            pc2_d  = cls_rd;
            ph_d   = 2'd0;
            if (i_q == last_i) begin
              state_d = S_CPY;
              i_d     = '0;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
        endcase
      end
      S_CPY: begin
        csc_ra = i_q;
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          cls_we = 1'b1;
          cls_wa = i_q;
          cls_wd = csc_rd;
          ph_d   = 2'd0;
          if (i_q == last_i) begin
            k_d = k_next;
            if (k_next < n_q) begin
              state_d = S_CLR;
              j_d     = '0;
            end else begin
              state_d = S_IDLE;
              built_d = 1'b1;
            end
          end else begin
            i_d = i_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      len_q   <= '0;
      built_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      len_q   <= len_d;
      built_q <= built_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;    k_q   <= k_d;   i_q   <= i_d;   j_q   <= j_d;
    acc_q  <= acc_d;  h_q   <= h_d;   c_q   <= c_d;   p_q   <= p_d;
    b_q    <= b_d;    c1_q  <= c1_d;  pc1_q <= pc1_d; pc2_q <= pc2_d;
    inr_q  <= inr_d;  rank_q <= rank_d;
  end

  // Order RAM data for the read request lands the cycle after acceptance.
  assign res_valid_o        = rv_q;
  assign res_o.suffix_start = inr_q ? RANK_W'(ord_rd) : '0;
  assign res_o.rank_echo    = rank_q;
  assign res_o.out_of_range = !inr_q;

endmodule
